// ===== rtl/core/egc_pkg.sv =====
// Shared types and constants for the echogram gradient colorizer.
`default_nettype none

package egc_pkg;

	localparam int unsigned COLOR_W      = 15;
	localparam int unsigned LEVEL_W      = 8;
	localparam int unsigned STOP_W       = 32;
	localparam int unsigned PALETTE_SIZE = 256;
	localparam int unsigned CLASSIC_N    = 4;
	localparam int unsigned DIVIDEND_W   = 22;
	localparam int unsigned DIVISOR_W    = 9;
	localparam int unsigned QUOT_W       = 8;
	localparam int unsigned MAP_SCALE    = 100;

	// Operation codes of an input request
	localparam logic OP_MAP  = 1'b0;
	localparam logic OP_LOAD = 1'b1;

	// Configuration register indexes
	localparam logic [0:0] REG_LOW_LEVEL  = 1'b0;
	localparam logic [0:0] REG_HIGH_LEVEL = 1'b1;

	localparam logic [LEVEL_W-1:0] LOW_LEVEL_RESET  = 8'd10;
	localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RESET = 8'd100;

	typedef logic [STOP_W-1:0] stop_t;

	// Default gradient stops: level, red, green, blue
	localparam stop_t CLASSIC_STOPS [CLASSIC_N] = '{
		{8'd0,   8'd0,   8'd0,   8'd0},
		{8'd30,  8'd20,  8'd5,   8'd80},
		{8'd130, 8'd50,  8'd180, 8'd230},
		{8'd255, 8'd220, 8'd255, 8'd255}
	};

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [DIVISOR_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/egc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module egc_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, read one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/egc_qdiv.sv =====
// Iterative divider, one quotient bit per cycle, quotient clamped to 255.
`default_nettype none

module egc_qdiv (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire egc_pkg::div_req_t req,
	output egc_pkg::div_rsp_t    rsp
);

	logic                               busy_q;
	logic                               done_q;
	logic [2:0]                         step_q;
	logic [egc_pkg::DIVIDEND_W-1:0]     rem_q;
	logic [egc_pkg::DIVISOR_W-1:0]      den_q;
	logic [egc_pkg::QUOT_W-1:0]         quot_q;
	logic [egc_pkg::DIVIDEND_W-1:0]     shifted;
	logic                               fits;
	logic                               overflow;

	// Trial subtrahend for the current quotient bit
	assign shifted  = egc_pkg::DIVIDEND_W'(den_q) << step_q;
	assign fits     = (rem_q >= shifted);
	assign overflow = (req.dividend >= {5'b0, req.divisor, 8'b0});

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= !overflow;
				done_q <= overflow;
				step_q <= 3'd7;
			end else if (busy_q) begin
				if (step_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 3'd1;
				end
			end
		end
	end

	// Remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			den_q  <= req.divisor;
			quot_q <= overflow ? '1 : '0;
		end else if (busy_q && fits) begin
			rem_q          <= rem_q - shifted;
			quot_q[step_q] <= 1'b1;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

`default_nettype wire

// ===== rtl/core/echogram_gradient_colorizer.sv =====
// Echogram sample colorizer: level window, palette lookup and gradient rebuild.
//
//  channel | dir | handshake             | payload
//  in      | in  | in_valid / in_stall   | op, sample, stop_level, stop_red/green/blue, stop_last
//  out     | out | out_valid / out_stall | pixel_color, palette_index
//  cfg     | in  | cfg_write             | cfg_index, cfg_data
//
// A map request holds in_stall until its result enters the output register; the window
// divide may saturate at once or run the bit-serial divider through all eight quotient
// bits, and out_stall on a waiting result extends the hold. The last stop starts a
// palette rebuild of up to three channel divides per entry, under in_stall; after reset
// the default gradient is built the same way. A finished result waits in the output
// register under out_stall while the next request is accepted.
`default_nettype none

module echogram_gradient_colorizer #(
	parameter int unsigned MAX_STOPS = 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               op,
	input  wire logic signed [15:0] sample,
	input  wire logic [7:0]         stop_level,
	input  wire logic [7:0]         stop_red,
	input  wire logic [7:0]         stop_green,
	input  wire logic [7:0]         stop_blue,
	input  wire logic               stop_last,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [14:0]             pixel_color,
	output logic [7:0]              palette_index,
	input  wire logic               cfg_write,
	input  wire logic [0:0]         cfg_index,
	input  wire logic [7:0]         cfg_data
);

	localparam int unsigned AW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
	localparam int unsigned CW = $clog2(MAX_STOPS + 1);
	localparam int unsigned NW = (CW > 3) ? CW : 3;
	localparam int unsigned PW = $clog2(egc_pkg::PALETTE_SIZE);

	localparam logic [1:0] CH_RED   = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;
	localparam logic [1:0] CH_BLUE  = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MAP_START,
		S_MAP_DIV,
		S_MAP_RD,
		S_MAP_OUT,
		S_RB_FETCH,
		S_RB_LATCH,
		S_RB_CHECK,
		S_RB_MUL1,
		S_RB_MUL2,
		S_RB_NUM,
		S_RB_DIV,
		S_RB_WR
	} state_t;

	function automatic logic [7:0] chan_of(input egc_pkg::stop_t s, input logic [1:0] c);
		logic [7:0] v;
		unique case (c)
			CH_RED:   v = s[23:16];
			CH_GREEN: v = s[15:8];
			default:  v = s[7:0];
		endcase
		return v;
	endfunction

	state_t                       state_q;
	logic [7:0]                   low_q;
	logic [7:0]                   high_q;
	logic [CW-1:0]                cnt_q;
	logic [NW-1:0]                nstop_q;
	logic [NW-1:0]                fidx_q;
	logic                         classic_q;
	logic [8:0]                   lvl_q;
	logic [1:0]                   ch_q;
	logic                         out_valid_q;

	logic signed [16:0]           md_q;
	logic [PW-1:0]                idx_q;
	egc_pkg::stop_t               sa_q;
	egc_pkg::stop_t               sb_q;
	logic signed [18:0]           p_q;
	logic signed [19:0]           n_q;
	logic [egc_pkg::COLOR_W-1:0]  col_q;
	logic [egc_pkg::COLOR_W-1:0]  pixel_q;
	logic [PW-1:0]                pidx_q;

	logic                         in_accept;
	logic                         store_stop;
	logic [CW-1:0]                cnt_new;
	logic [10:0]                  low_x5;
	logic signed [16:0]           map_d;
	logic                         map_nonpos;
	logic                         span_pos;
	logic [7:0]                   span;
	logic [egc_pkg::DIVIDEND_W-1:0] md_x100;

	logic [7:0]                   ca;
	logic [7:0]                   cb;
	logic [7:0]                   la;
	logic [7:0]                   lb;
	logic signed [9:0]            dd;
	logic signed [9:0]            tt;
	logic signed [9:0]            dt;
	logic signed [18:0]           p_w;
	logic signed [19:0]           n_w;
	logic signed [20:0]           nadj;
	logic [7:0]                   absd;
	logic signed [21:0]           num_w;
	logic                         blend_div;
	logic [7:0]                   chan_direct;
	logic [4:0]                   chan5;
	logic                         chan_done;
	logic                         load_out;

	egc_pkg::stop_t               stop_wdata;
	egc_pkg::stop_t               stop_rdata;
	logic [egc_pkg::COLOR_W-1:0]  pal_rdata;
	logic                         pal_we;
	logic [PW-1:0]                pal_raddr;

	egc_pkg::div_req_t            div_req;
	egc_pkg::div_rsp_t            div_rsp;

	// Input handshake
	assign in_stall   = (state_q != S_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign store_stop = in_accept && (op == egc_pkg::OP_LOAD) && (cnt_q < CW'(MAX_STOPS));
	assign cnt_new    = (cnt_q < CW'(MAX_STOPS)) ? cnt_q + CW'(1) : cnt_q;
	assign stop_wdata = {stop_level, stop_red, stop_green, stop_blue};

	// Level window: offset and sample distance
	assign low_x5     = {3'b0, low_q} + {1'b0, low_q, 2'b0};
	assign map_d      = $signed({sample[15], sample}) - $signed({7'b0, low_x5[10:1]});
	assign map_nonpos = md_q[16] || (md_q == '0);
	assign span_pos   = (high_q > low_q);
	assign span       = high_q - low_q;
	assign md_x100    = egc_pkg::DIVIDEND_W'(md_q[14:0]) *
		egc_pkg::DIVIDEND_W'(egc_pkg::MAP_SCALE);

	// Segment blend terms
	assign la   = sa_q[31:24];
	assign lb   = sb_q[31:24];
	assign ca   = chan_of(sa_q, ch_q);
	assign cb   = chan_of(sb_q, ch_q);
	assign dd   = $signed({2'b0, lb}) - $signed({2'b0, la});
	assign tt   = $signed({1'b0, lvl_q}) - $signed({2'b0, la});
	assign dt   = $signed({2'b0, lb}) - $signed({1'b0, lvl_q});
	assign p_w  = $signed({1'b0, ca}) * dt;
	assign n_w  = p_q + ($signed({1'b0, cb}) * tt);
	assign nadj = dd[9] ? -n_q : n_q;
	assign absd = dd[9] ? 8'(-dd) : dd[7:0];
	assign num_w = (nadj <<< 1) + $signed({14'b0, absd});
	assign blend_div   = (dd != '0) && (num_w > 22'sd0);
	assign chan_direct = (dd == '0) ? ca : 8'd0;
	assign chan5       = (state_q == S_RB_DIV) ? div_rsp.quot[7:3] : chan_direct[7:3];
	assign chan_done   = ((state_q == S_RB_NUM) && !blend_div) ||
		((state_q == S_RB_DIV) && div_rsp.done);

	// Shared divider request
	always_comb begin
		div_req.start    = ((state_q == S_MAP_START) && !map_nonpos && span_pos) ||
			((state_q == S_RB_NUM) && blend_div);
		div_req.dividend = (state_q == S_MAP_START) ? md_x100 : num_w[21:0];
		div_req.divisor  = (state_q == S_MAP_START) ? {1'b0, span} : {absd, 1'b0};
	end

	egc_qdiv u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Stop store
	egc_ram #(
		.WIDTH (egc_pkg::STOP_W),
		.DEPTH (1 << AW)
	) u_stop_ram (
		.clk   (clk),
		.we    (store_stop),
		.waddr (cnt_q[AW-1:0]),
		.wdata (stop_wdata),
		.raddr (fidx_q[AW-1:0]),
		.rdata (stop_rdata)
	);

	// Palette store
	assign pal_we    = (state_q == S_RB_WR);
	assign pal_raddr = idx_q;

	egc_ram #(
		.WIDTH (egc_pkg::COLOR_W),
		.DEPTH (egc_pkg::PALETTE_SIZE)
	) u_pal_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (lvl_q[PW-1:0]),
		.wdata (col_q),
		.raddr (pal_raddr),
		.rdata (pal_rdata)
	);

	assign load_out = (state_q == S_MAP_OUT) && (!out_valid_q || !out_stall);

	// Sequencer, configuration and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_RB_FETCH;
			low_q       <= egc_pkg::LOW_LEVEL_RESET;
			high_q      <= egc_pkg::HIGH_LEVEL_RESET;
			cnt_q       <= '0;
			nstop_q     <= NW'(egc_pkg::CLASSIC_N);
			fidx_q      <= '0;
			classic_q   <= 1'b1;
			lvl_q       <= '0;
			ch_q        <= CH_RED;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (cfg_index)
					egc_pkg::REG_LOW_LEVEL:  low_q  <= cfg_data;
					egc_pkg::REG_HIGH_LEVEL: high_q <= cfg_data;
				endcase
			end

			// Raise a result when it is loaded, drop it once taken
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_accept && (op == egc_pkg::OP_MAP)) begin
						state_q <= S_MAP_START;
					end else if (in_accept) begin
						cnt_q <= stop_last ? CW'(0) : cnt_new;
						if (stop_last) begin
							if (cnt_new >= CW'(2)) begin
								nstop_q   <= NW'(cnt_new);
								fidx_q    <= '0;
								classic_q <= 1'b0;
								lvl_q     <= '0;
								state_q   <= S_RB_FETCH;
							end
						end
					end
				end
				S_MAP_START: begin
					state_q <= div_req.start ? S_MAP_DIV : S_MAP_RD;
				end
				S_MAP_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_MAP_RD;
					end
				end
				S_MAP_RD: begin
					state_q <= S_MAP_OUT;
				end
				S_MAP_OUT: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				S_RB_FETCH: begin
					state_q <= S_RB_LATCH;
				end
				S_RB_LATCH: begin
					if (fidx_q == '0) begin
						fidx_q  <= NW'(1);
						state_q <= S_RB_FETCH;
					end else begin
						state_q <= S_RB_CHECK;
					end
				end
				S_RB_CHECK: begin
					if ({1'b0, lb} >= lvl_q) begin
						ch_q    <= CH_RED;
						state_q <= S_RB_MUL1;
					end else if (({1'b0, fidx_q} + (NW+1)'(1)) < {1'b0, nstop_q}) begin
						fidx_q  <= fidx_q + NW'(1);
						state_q <= S_RB_FETCH;
					end else begin
						classic_q <= 1'b0;
						state_q   <= S_IDLE;
					end
				end
				S_RB_MUL1: begin
					state_q <= S_RB_MUL2;
				end
				S_RB_MUL2: begin
					state_q <= S_RB_NUM;
				end
				S_RB_NUM, S_RB_DIV: begin
					if (state_q == S_RB_NUM && blend_div) begin
						state_q <= S_RB_DIV;
					end else if (chan_done) begin
						if (ch_q == CH_BLUE) begin
							state_q <= S_RB_WR;
						end else begin
							ch_q    <= ch_q + 2'd1;
							state_q <= S_RB_MUL1;
						end
					end
				end
				S_RB_WR: begin
					lvl_q   <= lvl_q + 9'd1;
					state_q <= S_RB_CHECK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_accept && (op == egc_pkg::OP_MAP)) begin
			md_q <= map_d;
		end
		if (state_q == S_MAP_START) begin
			idx_q <= map_nonpos ? '0 : '1;
		end
		if ((state_q == S_MAP_DIV) && div_rsp.done) begin
			idx_q <= div_rsp.quot;
		end
		if (state_q == S_RB_LATCH) begin
			sa_q <= sb_q;
			sb_q <= classic_q ? egc_pkg::CLASSIC_STOPS[fidx_q[1:0]] : stop_rdata;
		end
		if (state_q == S_RB_MUL1) begin
			p_q <= p_w;
		end
		if (state_q == S_RB_MUL2) begin
			n_q <= n_w;
		end
		if (chan_done) begin
			unique case (ch_q)
				CH_RED:   col_q[14:10] <= chan5;
				CH_GREEN: col_q[9:5]   <= chan5;
				default:  col_q[4:0]   <= chan5;
			endcase
		end
		if (load_out) begin
			pixel_q <= pal_rdata;
			pidx_q  <= idx_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_color   = pixel_q;
	assign palette_index = pidx_q;

endmodule

`default_nettype wire

// ===== rtl/core/egc_checker.sv =====
// Port-level checks for the echogram gradient colorizer and their binding.
`default_nettype none

module egc_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire logic               op,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic [14:0]        pixel_color,
	input wire logic [7:0]         palette_index
);

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pixel_color) &&
			$stable(palette_index))
		else $error("stalled result changed or dropped");

	// Block intake while a map request is at work
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == egc_pkg::OP_MAP) |=> in_stall)
		else $error("request accepted while a map request is in flight");

	// Raise no result on a stop load
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (op == egc_pkg::OP_LOAD) |=> !$rose(out_valid))
		else $error("stop load produced a result");

	// Raise a result only after intake was held
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a request in flight");

endmodule

bind echogram_gradient_colorizer egc_checker u_egc_checker (.*);

`default_nettype wire
